// ----- hw/rtl/spcm_pkg.sv -----
package spcm_pkg;

  localparam int SZ_W       = 14;
  localparam int ORG_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  localparam logic [SZ_W-1:0] SCREEN_W_RST = SZ_W'(1920);
  localparam logic [SZ_W-1:0] SCREEN_H_RST = SZ_W'(1080);

  // move threshold: diff * MOVE_DEN >= size * MOVE_NUM
  localparam int MOVE_NUM = 13;
  localparam int MOVE_DEN = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_W = 3'd0,
    CFG_SCREEN_H = 3'd1,
    CFG_SCREEN_L = 3'd2,
    CFG_SCREEN_T = 3'd3,
    CFG_FULL_W   = 3'd4,
    CFG_FULL_H   = 3'd5,
    CFG_REL_W    = 3'd6,
    CFG_REL_H    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SZ_W-1:0]         sw;
    logic [SZ_W-1:0]         sh;
    logic signed [ORG_W-1:0] sl;
    logic signed [ORG_W-1:0] st;
    logic [SZ_W-1:0]         faw;
    logic [SZ_W-1:0]         fah;
    logic [SZ_W-1:0]         raw;
    logic [SZ_W-1:0]         rah;
  } cfg_t;

endpackage

// ----- hw/rtl/spring_cursor_mapper.sv -----
// spring cursor mapper
//
// input channel: in_valid_i / in_stall_o, one transaction per spring sample with the full
// and relative displacements and the current cursor position. output channel:
// out_valid_o / out_stall_i, exactly one result transaction per input transaction, in order.
// configuration: cfg_valid_i / cfg_ready_o with a register index and data; ready is always
// high, writes are meant for idle periods only.
//
// four register stages: input capture, products, scaled spring point, result.
// one transaction per cycle is sustained while the receiver does not stall. pivot,
// previous cursor and moving flag live in single registers updated as an item enters
// the result register, so back to back items see each other's state.
//
// reset clears all stage valids, the pivot (none), previous cursor (zero), moving flag,
// and loads the default screen geometry. when the receiver stalls, the result is held
// and bubbles in the pipeline fill up; in_stall_o rises only once every stage is full.
module spring_cursor_mapper #(
  parameter int COORD_BITS = spcm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = spcm_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spcm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spcm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [FRAC_BITS+3:0]       full_disp_x_i,
  input  logic signed [FRAC_BITS+3:0]       full_disp_y_i,
  input  logic                              rel_present_i,
  input  logic signed [FRAC_BITS+3:0]       rel_disp_x_i,
  input  logic signed [FRAC_BITS+3:0]       rel_disp_y_i,
  input  logic signed [COORD_BITS-1:0]      cursor_x_i,
  input  logic signed [COORD_BITS-1:0]      cursor_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              spring_active_o,
  output logic signed [COORD_BITS-1:0]      dest_x_o,
  output logic signed [COORD_BITS-1:0]      dest_y_o,
  output logic                              move_valid_o,
  output logic signed [COORD_BITS-1:0]      move_dx_o,
  output logic signed [COORD_BITS-1:0]      move_dy_o,
  output logic                              restart_timer_o
);
  import spcm_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = FRAC_BITS + 4;
  localparam int PPW  = DW + SZ_W;
  localparam int PW   = PPW + 1;
  localparam int FW   = PW - FRAC_BITS;
  localparam int FSW  = ((FW > ORG_W) ? FW : ORG_W) + 1;
  localparam int RPW  = DW + SZ_W + 1;
  localparam int OW   = RPW - FRAC_BITS - 1;
  localparam int XSW  = ((CB > OW) ? CB : OW) + 1;
  localparam int USW  = ((CB > ORG_W) ? CB : ORG_W) + 1;
  localparam int SATW = (((FSW > XSW) ? FSW : XSW) > USW) ? ((FSW > XSW) ? FSW : XSW) : USW;
  localparam int AW   = CB + 1;
  localparam int AMW  = AW + 10;
  localparam int TW   = SZ_W + 4;
  localparam int MIDP = PW - (SZ_W - 1) - FRAC_BITS;

  localparam logic signed [DW-1:0]   WIN_LO  = DW'(-(2 << FRAC_BITS));
  localparam logic signed [DW-1:0]   WIN_HI  = DW'(1 << FRAC_BITS);
  localparam logic signed [DW-1:0]   NEG_ONE = DW'(-(1 << FRAC_BITS));
  localparam logic signed [PW-1:0]   FX_BIAS = PW'((1 << FRAC_BITS) - 1);
  localparam logic signed [RPW-1:0]  RX_BIAS = RPW'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [SATW-1:0] SAT_HI  = SATW'((1 << (CB - 1)) - 1);
  localparam logic signed [SATW-1:0] SAT_LO  = SATW'(-(1 << (CB - 1)));
  localparam logic [SZ_W-1:0]        SZ_TWO  = SZ_W'(2);

  function automatic logic signed [CB-1:0] sat_c(input logic signed [SATW-1:0] v);
    logic signed [CB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[CB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  // configuration and derived geometry
  cfg_t                    cfg;
  logic signed [ORG_W-1:0] scr_left;
  logic signed [ORG_W-1:0] scr_top;
  logic [SZ_W-2:0]         midw;
  logic [SZ_W-2:0]         midh;
  logic [SZ_W-1:0]         dsw;
  logic [SZ_W-1:0]         dsh;
  logic                    rel_area_ok;
  logic [TW-1:0]           thr_sw;
  logic [TW-1:0]           thr_sh;
  logic [TW-1:0]           thr_rw;
  logic [TW-1:0]           thr_rh;
  logic signed [USW-1:0]   cen_x;
  logic signed [USW-1:0]   cen_y;

  spcm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign scr_left = cfg.sl;
  assign scr_top  = cfg.st;
  assign midw     = cfg.sw[SZ_W-1:1];
  assign midh     = cfg.sh[SZ_W-1:1];

  always_comb begin
    if (cfg.faw >= SZ_TWO && cfg.fah >= SZ_TWO) begin
      dsw = (cfg.faw < cfg.sw) ? cfg.faw : cfg.sw;
      dsh = (cfg.fah < cfg.sh) ? cfg.fah : cfg.sh;
    end else begin
      dsw = cfg.sw;
      dsh = cfg.sh;
    end
  end

  assign rel_area_ok = (cfg.raw >= SZ_TWO) && (cfg.rah >= SZ_TWO);
  assign thr_sw = TW'(dsw) * TW'(MOVE_NUM);
  assign thr_sh = TW'(dsh) * TW'(MOVE_NUM);
  assign cen_x  = USW'(scr_left) + $signed(USW'(midw));
  assign cen_y  = USW'(scr_top) + $signed(USW'(midh));

  // pipeline handshake
  logic s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic s1_en, s2_en, s3_en, out_en, fire;

  assign out_en     = !out_vld_q || !out_stall_i;
  assign s3_en      = !s3_vld_q || out_en;
  assign s2_en      = !s2_vld_q || s3_en;
  assign s1_en      = !s1_vld_q || s2_en;
  assign in_stall_o = !s1_en;
  assign fire       = s3_vld_q && out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_vld_q <= s1_vld_q;
      end
      if (s3_en) begin
        s3_vld_q <= s2_vld_q;
      end
      if (out_en) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  // stage 1: input capture
  logic signed [DW-1:0] s1_fdx_q, s1_fdy_q, s1_rdx_q, s1_rdy_q;
  logic                 s1_rel_q;
  logic signed [CB-1:0] s1_cx_q, s1_cy_q;

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_fdx_q <= full_disp_x_i;
      s1_fdy_q <= full_disp_y_i;
      s1_rel_q <= rel_present_i;
      s1_rdx_q <= rel_disp_x_i;
      s1_rdy_q <= rel_disp_y_i;
      s1_cx_q  <= cursor_x_i;
      s1_cy_q  <= cursor_y_i;
    end
  end

  // stage 2: window check and products
  logic                  s1_act;
  logic signed [PPW-1:0] s1_prod_fx, s1_prod_fy;
  logic signed [RPW-1:0] s1_prod_rx, s1_prod_ry;

  assign s1_act = (s1_fdx_q >= WIN_LO && s1_fdx_q <= WIN_HI &&
                   s1_fdy_q >= WIN_LO && s1_fdy_q <= WIN_HI) ||
                  (s1_rel_q && s1_rdx_q >= WIN_LO && s1_rdx_q <= WIN_HI &&
                   s1_rdy_q >= WIN_LO && s1_rdy_q <= WIN_HI);
  assign s1_prod_fx = s1_fdx_q * $signed({1'b0, dsw[SZ_W-1:1]});
  assign s1_prod_fy = s1_fdy_q * $signed({1'b0, dsh[SZ_W-1:1]});
  assign s1_prod_rx = s1_rdx_q * $signed({1'b0, cfg.raw});
  assign s1_prod_ry = s1_rdy_q * $signed({1'b0, cfg.rah});

  logic                  s2_act_q, s2_rel_q;
  logic                  s2_fuse_x_q, s2_fuse_y_q, s2_ruse_x_q, s2_ruse_y_q;
  logic signed [PPW-1:0] s2_prod_fx_q, s2_prod_fy_q;
  logic signed [RPW-1:0] s2_prod_rx_q, s2_prod_ry_q;
  logic signed [CB-1:0]  s2_cx_q, s2_cy_q;

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_vld_q) begin
      s2_act_q     <= s1_act;
      s2_rel_q     <= s1_rel_q;
      s2_fuse_x_q  <= s1_fdx_q >= NEG_ONE;
      s2_fuse_y_q  <= s1_fdy_q >= NEG_ONE;
      s2_ruse_x_q  <= s1_rdx_q >= NEG_ONE;
      s2_ruse_y_q  <= s1_rdy_q >= NEG_ONE;
      s2_prod_fx_q <= s1_prod_fx;
      s2_prod_fy_q <= s1_prod_fy;
      s2_prod_rx_q <= s1_prod_rx;
      s2_prod_ry_q <= s1_prod_ry;
      s2_cx_q      <= s1_cx_q;
      s2_cy_q      <= s1_cy_q;
    end
  end

  // stage 3: spring point and relative offset, truncated toward zero
  logic signed [PW-1:0]  mid_x_sh, mid_y_sh, num_x, num_y, shf_x, shf_y;
  logic signed [FW-1:0]  fxr, fyr;
  logic signed [FSW-1:0] fsum_x, fsum_y;
  logic signed [RPW-1:0] shr_x, shr_y;
  logic                  rel_apply;
  logic signed [OW-1:0]  ox, oy;

  assign mid_x_sh = $signed({{MIDP{1'b0}}, midw, {FRAC_BITS{1'b0}}});
  assign mid_y_sh = $signed({{MIDP{1'b0}}, midh, {FRAC_BITS{1'b0}}});
  assign num_x    = mid_x_sh + PW'(s2_prod_fx_q);
  assign num_y    = mid_y_sh + PW'(s2_prod_fy_q);
  assign shf_x    = (num_x + (num_x[PW-1] ? FX_BIAS : '0)) >>> FRAC_BITS;
  assign shf_y    = (num_y + (num_y[PW-1] ? FX_BIAS : '0)) >>> FRAC_BITS;
  assign fxr      = shf_x[FW-1:0];
  assign fyr      = shf_y[FW-1:0];
  assign fsum_x   = FSW'(fxr) + FSW'(scr_left);
  assign fsum_y   = FSW'(fyr) + FSW'(scr_top);

  assign rel_apply = s2_rel_q && rel_area_ok;
  assign shr_x = (s2_prod_rx_q + (s2_prod_rx_q[RPW-1] ? RX_BIAS : '0)) >>> (FRAC_BITS + 1);
  assign shr_y = (s2_prod_ry_q + (s2_prod_ry_q[RPW-1] ? RX_BIAS : '0)) >>> (FRAC_BITS + 1);
  assign ox    = (rel_apply && s2_ruse_x_q) ? shr_x[OW-1:0] : '0;
  assign oy    = (rel_apply && s2_ruse_y_q) ? shr_y[OW-1:0] : '0;

  logic                 s3_act_q, s3_rel_q, s3_rapp_q;
  logic                 s3_fuse_x_q, s3_fuse_y_q, s3_ruse_x_q, s3_ruse_y_q;
  logic signed [CB-1:0] s3_fxu_q, s3_fyu_q, s3_cx_q, s3_cy_q;
  logic signed [OW-1:0] s3_ox_q, s3_oy_q;

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_vld_q) begin
      s3_act_q    <= s2_act_q;
      s3_rel_q    <= s2_rel_q;
      s3_rapp_q   <= rel_apply;
      s3_fuse_x_q <= s2_fuse_x_q;
      s3_fuse_y_q <= s2_fuse_y_q;
      s3_ruse_x_q <= s2_ruse_x_q;
      s3_ruse_y_q <= s2_ruse_y_q;
      s3_fxu_q    <= sat_c(SATW'(fsum_x));
      s3_fyu_q    <= sat_c(SATW'(fsum_y));
      s3_ox_q     <= ox;
      s3_oy_q     <= oy;
      s3_cx_q     <= s2_cx_q;
      s3_cy_q     <= s2_cy_q;
    end
  end

  // result stage: pivot, move decision, state update
  logic                 piv_vld_q, moving_q, moving_d;
  logic signed [CB-1:0] piv_x_q, piv_y_q, prev_x_q, prev_y_q;
  logic signed [CB-1:0] px, py, fx, fy, x, y;
  logic signed [USW-1:0] ux_sum, uy_sum;
  logic signed [AW-1:0] dx_s, dy_s;
  logic [AW-1:0]        ax, ay;
  logic [AMW-1:0]       ax_k, ay_k;
  logic                 diff, center, big_rel, big_full, small_step;
  logic                 mv, timer, upd;

  assign px     = (s3_rel_q && piv_vld_q) ? piv_x_q : s3_cx_q;
  assign py     = (s3_rel_q && piv_vld_q) ? piv_y_q : s3_cy_q;
  assign ux_sum = USW'(px) + USW'(scr_left);
  assign uy_sum = USW'(py) + USW'(scr_top);
  assign fx     = s3_fuse_x_q ? s3_fxu_q : sat_c(SATW'(ux_sum));
  assign fy     = s3_fuse_y_q ? s3_fyu_q : sat_c(SATW'(uy_sum));
  assign x      = sat_c(SATW'(fx) + SATW'(s3_ox_q));
  assign y      = sat_c(SATW'(fy) + SATW'(s3_oy_q));

  assign dx_s = AW'(s3_cx_q) - AW'(x);
  assign dy_s = AW'(s3_cy_q) - AW'(y);
  assign ax   = dx_s[AW-1] ? $unsigned(-dx_s) : $unsigned(dx_s);
  assign ay   = dy_s[AW-1] ? $unsigned(-dy_s) : $unsigned(dy_s);
  assign ax_k = AMW'(ax) * AMW'(MOVE_DEN);
  assign ay_k = AMW'(ay) * AMW'(MOVE_DEN);

  assign thr_rw = s3_rapp_q ? TW'(cfg.raw) * TW'(MOVE_NUM) : '0;
  assign thr_rh = s3_rapp_q ? TW'(cfg.rah) * TW'(MOVE_NUM) : '0;

  assign diff       = (x != s3_cx_q) || (y != s3_cy_q);
  assign center     = (USW'(x) == cen_x) || (USW'(y) == cen_y);
  assign big_rel    = s3_rel_q && (s3_ruse_x_q || s3_ruse_y_q) &&
                      (ax_k >= AMW'(thr_rw) || ay_k >= AMW'(thr_rh));
  assign big_full   = ax_k >= AMW'(thr_sw) || ay_k >= AMW'(thr_sh);
  assign small_step = (ax < AW'(2)) && (ay < AW'(2));

  always_comb begin
    mv       = 1'b0;
    timer    = 1'b0;
    upd      = 1'b0;
    moving_d = moving_q;
    if (!s3_act_q) begin
      moving_d = 1'b0;
    end else if (diff) begin
      upd = 1'b1;
      if (center) begin
        mv = 1'b1;
      end else if (!moving_q && big_rel) begin
        moving_d = 1'b1;
        mv       = 1'b1;
        timer    = 1'b1;
      end else if (!moving_q && big_full) begin
        moving_d = 1'b1;
        mv       = 1'b1;
        timer    = 1'b1;
      end else if (moving_q && small_step) begin
        moving_d = 1'b0;
      end else if (moving_q) begin
        mv    = 1'b1;
        timer = 1'b1;
      end
    end else if (prev_x_q == x && prev_y_q == y) begin
      moving_d = 1'b0;
    end else begin
      upd   = 1'b1;
      timer = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piv_vld_q <= 1'b0;
      moving_q  <= 1'b0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (fire) begin
      moving_q <= moving_d;
      if (!s3_act_q) begin
        piv_vld_q <= 1'b0;
      end else if (upd) begin
        piv_vld_q <= 1'b1;
        prev_x_q  <= s3_cx_q;
        prev_y_q  <= s3_cy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s3_act_q && upd) begin
      piv_x_q <= fx;
      piv_y_q <= fy;
    end
  end

  logic                 act_q, mv_q, timer_q;
  logic signed [CB-1:0] dest_x_q, dest_y_q, mdx_q, mdy_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      act_q    <= s3_act_q;
      dest_x_q <= s3_act_q ? x : '0;
      dest_y_q <= s3_act_q ? y : '0;
      mv_q     <= s3_act_q && mv;
      mdx_q    <= (s3_act_q && mv) ? sat_c(SATW'(x) - SATW'(s3_cx_q)) : '0;
      mdy_q    <= (s3_act_q && mv) ? sat_c(SATW'(y) - SATW'(s3_cy_q)) : '0;
      timer_q  <= s3_act_q && timer;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign spring_active_o = act_q;
  assign dest_x_o        = dest_x_q;
  assign dest_y_o        = dest_y_q;
  assign move_valid_o    = mv_q;
  assign move_dx_o       = mdx_q;
  assign move_dy_o       = mdy_q;
  assign restart_timer_o = timer_q;

`ifndef SYNTHESIS
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !spring_active_o |-> !move_valid_o && !restart_timer_o &&
      dest_x_o == '0 && dest_y_o == '0)
    else $error("inactive result carries nonzero fields");

  a_no_move_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !move_valid_o |-> move_dx_o == '0 && move_dy_o == '0)
    else $error("move offsets set without a move");

  a_inactive_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !s3_act_q |=> !piv_vld_q && !moving_q)
    else $error("inactive item left pivot or moving flag set");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q && s2_vld_q && s3_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ----- hw/rtl/spcm_cfg_regs.sv -----
module spcm_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spcm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spcm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output spcm_pkg::cfg_t                    cfg_o
);
  import spcm_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  cfg_idx_e idx;

  assign cfg_ready_o = 1'b1;
  assign idx         = cfg_idx_e'(cfg_index_i);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (idx)
        CFG_SCREEN_W: cfg_d.sw  = cfg_data_i[SZ_W-1:0];
        CFG_SCREEN_H: cfg_d.sh  = cfg_data_i[SZ_W-1:0];
        CFG_SCREEN_L: cfg_d.sl  = $signed(cfg_data_i[ORG_W-1:0]);
        CFG_SCREEN_T: cfg_d.st  = $signed(cfg_data_i[ORG_W-1:0]);
        CFG_FULL_W:   cfg_d.faw = cfg_data_i[SZ_W-1:0];
        CFG_FULL_H:   cfg_d.fah = cfg_data_i[SZ_W-1:0];
        CFG_REL_W:    cfg_d.raw = cfg_data_i[SZ_W-1:0];
        CFG_REL_H:    cfg_d.rah = cfg_data_i[SZ_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sw  <= SCREEN_W_RST;
      cfg_q.sh  <= SCREEN_H_RST;
      cfg_q.sl  <= '0;
      cfg_q.st  <= '0;
      cfg_q.faw <= '0;
      cfg_q.fah <= '0;
      cfg_q.raw <= '0;
      cfg_q.rah <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
